/* design/refcounted_buffer_pool_defines.svh */
// Assertion macros for the buffer pool.
`ifndef REFCOUNTED_BUFFER_POOL_DEFINES_SVH
`define REFCOUNTED_BUFFER_POOL_DEFINES_SVH
`ifndef SYNTHESIS
`define RBP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("refcounted_buffer_pool: check failed");
`define RBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("refcounted_buffer_pool: check failed");
`else
`define RBP_ASSERT_SAME(lbl, ante, cons)
`define RBP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/rbp_pkg.sv */
// Types and constants of the buffer pool.
package rbp_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_LINK  = 2'd2,
    FUNC_INIT  = 2'd3
  } func_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TOO_LONG    = 2'd1;
  localparam logic [1:0] ST_NO_RESOURCE = 2'd2;

  localparam int PADDR_W    = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_BUFFER_SIZE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_COUNT   = 2'd2;

  localparam int BCOUNT_W = 7;
  localparam int VCOUNT_W = 8;
  localparam int REF_W    = 8;

  localparam int BUFFER_SIZE_RST  = 2048;
  localparam int BUFFER_COUNT_RST = 64;
  localparam int VIEW_COUNT_RST   = 128;

endpackage

/* design/refcounted_buffer_pool.sv */
// Reference-counted packet buffer pool with buffer and view free lists.
//
// Input words (in_valid/in_ready) carry func, length and view_id; every word gives exactly
// one result word on out_valid/out_ready. Write registers over the APB port only while idle
// (not enforced). State lives in two memories with registered reads: view table (free-list
// slot, buffer, offset per row), buffer table (free-list slot, reference count per row).
// States per word, set by the chain of dependent memory reads: alloc S_EXEC; link S_EXEC,
//   S_LINK_CNT; free S_EXEC, S_FREE_CNT, S_FREE_PUSH (only when the buffer returns to the
//   free list); init S_EXEC, S_SWEEP (saturated buffer_count entries, one cleared per cycle).
// With room at the output, the result is registered and visible the cycle after its last step.
// Reset gives the pool as after init with the reset register values; no clearing pass.
// If the receiver stalls, the result stays in the output register while the next word is
// still accepted and worked; its result waits in a hold register until the output frees.
`include "refcounted_buffer_pool_defines.svh"

module refcounted_buffer_pool #(
  parameter int MAX_BUFFERS = 64,
  parameter int MAX_VIEWS   = 128,
  parameter int SIZE_BITS   = 16,
  localparam int BW  = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1,
  localparam int VW  = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1,
  localparam int BCW = $clog2(MAX_BUFFERS + 1),
  localparam int VCW = $clog2(MAX_VIEWS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [SIZE_BITS-1:0]            in_length,
  input  logic [VW-1:0]                   in_view_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [VW-1:0]                   out_new_view,
  output logic [BW-1:0]                   out_buffer_id,
  output logic [SIZE_BITS-1:0]            out_data_offset,
  output logic [BCW-1:0]                  out_free_buffers,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbp_pkg::PADDR_W-1:0]     paddr,
  input  logic [rbp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rbp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam logic [BCW-1:0] RST_NB = BCW'((rbp_pkg::BUFFER_COUNT_RST > MAX_BUFFERS) ?
                                           MAX_BUFFERS : rbp_pkg::BUFFER_COUNT_RST);
  localparam logic [VCW-1:0] RST_NV = VCW'((rbp_pkg::VIEW_COUNT_RST > MAX_VIEWS) ?
                                           MAX_VIEWS : rbp_pkg::VIEW_COUNT_RST);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FREE_CNT,
    S_FREE_PUSH,
    S_LINK_CNT,
    S_SWEEP,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [VW-1:0]        stk;
    logic [BW-1:0]        bufid;
    logic [SIZE_BITS-1:0] off;
  } vrow_t;

  typedef struct packed {
    logic [BW-1:0]               stk;
    logic [rbp_pkg::REF_W-1:0]   cnt;
  } brow_t;

  vrow_t vmem [MAX_VIEWS];
  brow_t bmem [MAX_BUFFERS];

  vrow_t vm_pop_q, vm_vid_q;
  brow_t bm_q;

  state_t state_r, state_nxt;
  rbp_pkg::func_t func_r, func_nxt;
  logic [SIZE_BITS-1:0] len_r, len_nxt;
  logic [VW-1:0]        vid_r, vid_nxt;

  logic [SIZE_BITS-1:0]         size_r, size_nxt;
  logic [rbp_pkg::BCOUNT_W-1:0] bcount_r, bcount_nxt;
  logic [rbp_pkg::VCOUNT_W-1:0] vcount_r, vcount_nxt;

  logic [BCW-1:0] bst_top_r, bst_top_nxt, bfresh_r, bfresh_nxt, ftotal_r, ftotal_nxt;
  logic [VCW-1:0] vst_top_r, vst_top_nxt, vfresh_r, vfresh_nxt;
  logic [BCW-1:0] sweep_idx_r, sweep_idx_nxt, sweep_end_r, sweep_end_nxt;

  logic [BW-1:0]        cur_b_r, cur_b_nxt;
  logic [SIZE_BITS-1:0] cur_off_r, cur_off_nxt;
  logic [VW-1:0]        cur_v_r, cur_v_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt, hold_status_r, hold_status_nxt;
  logic [VW-1:0]        out_nview_r, out_nview_nxt, hold_nview_r, hold_nview_nxt;
  logic [BW-1:0]        out_bid_r, out_bid_nxt, hold_bid_r, hold_bid_nxt;
  logic [SIZE_BITS-1:0] out_off_r, out_off_nxt, hold_off_r, hold_off_nxt;
  logic [BCW-1:0]       out_free_r, out_free_nxt, hold_free_r, hold_free_nxt;

  logic                 vm_we_stk, vm_we_ent;
  logic [VW-1:0]        vm_waddr, vm_wstk, vm_pop_addr;
  logic [BW-1:0]        vm_wbuf;
  logic [SIZE_BITS-1:0] vm_woff;
  logic                 bm_we_stk, bm_we_cnt;
  logic [BW-1:0]        bm_waddr, bm_wstk, bm_raddr;
  logic [rbp_pkg::REF_W-1:0] bm_wcnt, cnt_dec;

  logic                 fin, out_room, accept, cfg_wr, b_avail, v_avail, vid_ok;
  logic [1:0]           res_status;
  logic [VW-1:0]        res_nview, pop_v;
  logic [BW-1:0]        res_bid, pop_b;
  logic [SIZE_BITS-1:0] res_off;
  logic [BCW-1:0]       nb;
  logic [VCW-1:0]       nv;
  logic [rbp_pkg::REG_IDX_W-1:0] reg_idx;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign reg_idx  = paddr[rbp_pkg::PADDR_W-1:2];
  assign cfg_wr   = psel && penable && pwrite;
  assign out_room = !out_valid_r || out_ready;

  assign b_avail = (bst_top_r != '0) || (bfresh_r != '0);
  assign v_avail = (vst_top_r != '0) || (vfresh_r != '0);
  assign vid_ok  = VCW'(vid_r) < VCW'(MAX_VIEWS);
  assign nb = (32'(bcount_r) > 32'(MAX_BUFFERS)) ? BCW'(MAX_BUFFERS) : BCW'(bcount_r);
  assign nv = (32'(vcount_r) > 32'(MAX_VIEWS)) ? VCW'(MAX_VIEWS) : VCW'(vcount_r);
  assign vm_pop_addr = VW'(vst_top_r - 1'b1);
  assign cnt_dec = bm_q.cnt - rbp_pkg::REF_W'(1);

  always_comb begin
    case (reg_idx)
      rbp_pkg::REG_BUFFER_SIZE:  prdata = rbp_pkg::CFG_DATA_W'(size_r);
      rbp_pkg::REG_BUFFER_COUNT: prdata = rbp_pkg::CFG_DATA_W'(bcount_r);
      rbp_pkg::REG_VIEW_COUNT:   prdata = rbp_pkg::CFG_DATA_W'(vcount_r);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    len_nxt       = len_r;
    vid_nxt       = vid_r;
    size_nxt      = size_r;
    bcount_nxt    = bcount_r;
    vcount_nxt    = vcount_r;
    bst_top_nxt   = bst_top_r;
    bfresh_nxt    = bfresh_r;
    ftotal_nxt    = ftotal_r;
    vst_top_nxt   = vst_top_r;
    vfresh_nxt    = vfresh_r;
    sweep_idx_nxt = sweep_idx_r;
    sweep_end_nxt = sweep_end_r;
    cur_b_nxt     = cur_b_r;
    cur_off_nxt   = cur_off_r;
    cur_v_nxt     = cur_v_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_nview_nxt  = out_nview_r;
    out_bid_nxt    = out_bid_r;
    out_off_nxt    = out_off_r;
    out_free_nxt   = out_free_r;
    hold_status_nxt = hold_status_r;
    hold_nview_nxt  = hold_nview_r;
    hold_bid_nxt    = hold_bid_r;
    hold_off_nxt    = hold_off_r;
    hold_free_nxt   = hold_free_r;

    vm_we_stk = 1'b0;
    vm_we_ent = 1'b0;
    vm_waddr  = '0;
    vm_wstk   = '0;
    vm_wbuf   = '0;
    vm_woff   = '0;
    bm_we_stk = 1'b0;
    bm_we_cnt = 1'b0;
    bm_waddr  = '0;
    bm_wstk   = '0;
    bm_wcnt   = '0;
    bm_raddr  = BW'(bst_top_r - 1'b1);

    fin        = 1'b0;
    res_status = rbp_pkg::ST_OK;
    res_nview  = '0;
    res_bid    = '0;
    res_off    = '0;
    pop_v      = '0;
    pop_b      = '0;

    if (cfg_wr) begin
      case (reg_idx)
        rbp_pkg::REG_BUFFER_SIZE:  size_nxt = pwdata[SIZE_BITS-1:0];
        rbp_pkg::REG_BUFFER_COUNT: bcount_nxt = pwdata[rbp_pkg::BCOUNT_W-1:0];
        rbp_pkg::REG_VIEW_COUNT:   vcount_nxt = pwdata[rbp_pkg::VCOUNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt  = rbp_pkg::func_t'(in_func);
          len_nxt   = in_length;
          vid_nxt   = in_view_id;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_r)
          rbp_pkg::FUNC_ALLOC: begin
            fin = 1'b1;
            if (len_r > size_r) begin
              res_status = rbp_pkg::ST_TOO_LONG;
            end else if (!b_avail || !v_avail) begin
              res_status = rbp_pkg::ST_NO_RESOURCE;
            end else begin
              if (vst_top_r != '0) begin
                pop_v       = vm_pop_q.stk;
                vst_top_nxt = vst_top_r - 1'b1;
              end else begin
                pop_v      = VW'(vfresh_r - 1'b1);
                vfresh_nxt = vfresh_r - 1'b1;
              end
              if (bst_top_r != '0) begin
                pop_b       = bm_q.stk;
                bst_top_nxt = bst_top_r - 1'b1;
              end else begin
                pop_b      = BW'(bfresh_r - 1'b1);
                bfresh_nxt = bfresh_r - 1'b1;
              end
              ftotal_nxt = ftotal_r - 1'b1;
              vm_we_ent  = 1'b1;
              vm_waddr   = pop_v;
              vm_wbuf    = pop_b;
              vm_woff    = size_r - len_r;
              bm_we_cnt  = 1'b1;
              bm_waddr   = pop_b;
              bm_wcnt    = rbp_pkg::REF_W'(1);
              res_nview  = pop_v;
              res_bid    = pop_b;
              res_off    = size_r - len_r;
            end
          end
          rbp_pkg::FUNC_FREE: begin
            if (vid_ok) begin
              cur_b_nxt   = vm_vid_q.bufid;
              cur_off_nxt = vm_vid_q.off;
              bm_raddr    = vm_vid_q.bufid;
              if (vst_top_r < VCW'(MAX_VIEWS)) begin
                vm_we_stk   = 1'b1;
                vm_waddr    = VW'(vst_top_r);
                vm_wstk     = vid_r;
                vst_top_nxt = vst_top_r + 1'b1;
              end
              state_nxt = S_FREE_CNT;
            end else begin
              fin = 1'b1;
            end
          end
          rbp_pkg::FUNC_LINK: begin
            if (!vid_ok || !v_avail) begin
              fin        = 1'b1;
              res_status = rbp_pkg::ST_NO_RESOURCE;
            end else begin
              if (vst_top_r != '0) begin
                pop_v       = vm_pop_q.stk;
                vst_top_nxt = vst_top_r - 1'b1;
              end else begin
                pop_v      = VW'(vfresh_r - 1'b1);
                vfresh_nxt = vfresh_r - 1'b1;
              end
              vm_we_ent   = 1'b1;
              vm_waddr    = pop_v;
              vm_wbuf     = vm_vid_q.bufid;
              vm_woff     = vm_vid_q.off;
              bm_raddr    = vm_vid_q.bufid;
              cur_b_nxt   = vm_vid_q.bufid;
              cur_off_nxt = vm_vid_q.off;
              cur_v_nxt   = pop_v;
              state_nxt   = S_LINK_CNT;
            end
          end
          rbp_pkg::FUNC_INIT: begin
            bst_top_nxt = '0;
            vst_top_nxt = '0;
            bfresh_nxt  = nb;
            vfresh_nxt  = nv;
            ftotal_nxt  = nb;
            if (nb != '0) begin
              sweep_idx_nxt = '0;
              sweep_end_nxt = nb;
              state_nxt     = S_SWEEP;
            end else begin
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_FREE_CNT: begin
        bm_we_cnt = 1'b1;
        bm_waddr  = cur_b_r;
        bm_wcnt   = cnt_dec;
        if (cnt_dec == '0 && bst_top_r < BCW'(MAX_BUFFERS)) begin
          state_nxt = S_FREE_PUSH;
        end else begin
          fin     = 1'b1;
          res_bid = cur_b_r;
          res_off = cur_off_r;
        end
      end
      S_FREE_PUSH: begin
        bm_we_stk   = 1'b1;
        bm_waddr    = BW'(bst_top_r);
        bm_wstk     = cur_b_r;
        bst_top_nxt = bst_top_r + 1'b1;
        ftotal_nxt  = ftotal_r + 1'b1;
        fin         = 1'b1;
        res_bid     = cur_b_r;
        res_off     = cur_off_r;
      end
      S_LINK_CNT: begin
        bm_we_cnt = 1'b1;
        bm_waddr  = cur_b_r;
        bm_wcnt   = bm_q.cnt + rbp_pkg::REF_W'(1);
        fin       = 1'b1;
        res_nview = cur_v_r;
        res_bid   = cur_b_r;
        res_off   = cur_off_r;
      end
      S_SWEEP: begin
        bm_we_cnt     = 1'b1;
        bm_waddr      = BW'(sweep_idx_r);
        bm_wcnt       = '0;
        sweep_idx_nxt = sweep_idx_r + 1'b1;
        if (sweep_idx_r == sweep_end_r - 1'b1) begin
          fin = 1'b1;
        end
      end
      S_HOLD: begin
        if (out_room) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = hold_status_r;
          out_nview_nxt  = hold_nview_r;
          out_bid_nxt    = hold_bid_r;
          out_off_nxt    = hold_off_r;
          out_free_nxt   = hold_free_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      if (out_room) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status;
        out_nview_nxt  = res_nview;
        out_bid_nxt    = res_bid;
        out_off_nxt    = res_off;
        out_free_nxt   = ftotal_nxt;
        state_nxt      = S_IDLE;
      end else begin
        hold_status_nxt = res_status;
        hold_nview_nxt  = res_nview;
        hold_bid_nxt    = res_bid;
        hold_off_nxt    = res_off;
        hold_free_nxt   = ftotal_nxt;
        state_nxt       = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vm_we_stk) begin
      vmem[vm_waddr].stk <= vm_wstk;
    end
    if (vm_we_ent) begin
      vmem[vm_waddr].bufid <= vm_wbuf;
      vmem[vm_waddr].off   <= vm_woff;
    end
    vm_pop_q <= vmem[vm_pop_addr];
    vm_vid_q <= vmem[in_view_id];
  end

  always_ff @(posedge clk) begin
    if (bm_we_stk) begin
      bmem[bm_waddr].stk <= bm_wstk;
    end
    if (bm_we_cnt) begin
      bmem[bm_waddr].cnt <= bm_wcnt;
    end
    bm_q <= bmem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_BITS'(rbp_pkg::BUFFER_SIZE_RST);
      bcount_r    <= rbp_pkg::BCOUNT_W'(rbp_pkg::BUFFER_COUNT_RST);
      vcount_r    <= rbp_pkg::VCOUNT_W'(rbp_pkg::VIEW_COUNT_RST);
      bst_top_r   <= '0;
      vst_top_r   <= '0;
      bfresh_r    <= RST_NB;
      vfresh_r    <= RST_NV;
      ftotal_r    <= RST_NB;
      sweep_idx_r <= '0;
      sweep_end_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      bcount_r    <= bcount_nxt;
      vcount_r    <= vcount_nxt;
      bst_top_r   <= bst_top_nxt;
      vst_top_r   <= vst_top_nxt;
      bfresh_r    <= bfresh_nxt;
      vfresh_r    <= vfresh_nxt;
      ftotal_r    <= ftotal_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      sweep_end_r <= sweep_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r        <= func_nxt;
    len_r         <= len_nxt;
    vid_r         <= vid_nxt;
    cur_b_r       <= cur_b_nxt;
    cur_off_r     <= cur_off_nxt;
    cur_v_r       <= cur_v_nxt;
    out_status_r  <= out_status_nxt;
    out_nview_r   <= out_nview_nxt;
    out_bid_r     <= out_bid_nxt;
    out_off_r     <= out_off_nxt;
    out_free_r    <= out_free_nxt;
    hold_status_r <= hold_status_nxt;
    hold_nview_r  <= hold_nview_nxt;
    hold_bid_r    <= hold_bid_nxt;
    hold_off_r    <= hold_off_nxt;
    hold_free_r   <= hold_free_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_new_view     = out_nview_r;
  assign out_buffer_id    = out_bid_r;
  assign out_data_offset  = out_off_r;
  assign out_free_buffers = out_free_r;

  `RBP_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
  `RBP_ASSERT_SAME(a_free_total, 1'b1, ftotal_r == BCW'(bst_top_r + bfresh_r))
  `RBP_ASSERT_SAME(a_sweep_bound, state_r == S_SWEEP, sweep_idx_r < sweep_end_r)

endmodule
